// File: rtl/core/pidc_pkg.sv
// pidc_pkg: shared widths, limits, register codes, state types and saturation
// helper for the clamped pid controller; no dependencies
package pidc_pkg;

  localparam int VALUE_W = 32;
  localparam int STEP_W  = 20;
  localparam int FRAC_W  = 16;
  localparam int LIM_W   = 31;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = ADDR_W - 2;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_LIMIT  = 3'd3,
    REG_INT_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] gain_p;
    logic signed [VALUE_W-1:0] gain_i;
    logic signed [VALUE_W-1:0] gain_d;
    logic [LIM_W-1:0]          out_limit;
    logic [LIM_W-1:0]          int_limit;
  } cfg_t;

  typedef struct packed {
    logic go;
    logic step_shift;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INC,
    ST_ACC,
    ST_CLAMP,
    ST_PROP,
    ST_INTG,
    ST_DIFF,
    ST_NUM,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } pidc_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHK,
    DIV_RUN,
    DIV_FIN
  } div_phase_t;

  function automatic logic signed [VALUE_W-1:0] sat_ext(input logic signed [VALUE_W:0] x);
    if (x[VALUE_W] != x[VALUE_W-1]) begin
      return x[VALUE_W] ? VMIN : VMAX;
    end
    return x[VALUE_W-1:0];
  endfunction

endpackage

// File: rtl/core/pidc_if.sv
// pidc_in_if / pidc_out_if: valid-ready channels for input and result words
// depends on pidc_pkg
interface pidc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::VALUE_W-1:0] target;
  logic signed [pidc_pkg::VALUE_W-1:0] measured;
  logic [pidc_pkg::STEP_W-1:0]         time_step;
  logic                               restart;

  modport source (output valid, output target, output measured, output time_step,
                  output restart, input ready);
  modport sink (input valid, input target, input measured, input time_step,
                input restart, output ready);
endinterface

interface pidc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::VALUE_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

// File: rtl/core/pidc_cfg.sv
// pidc_cfg: apb register file for gains and clamp limits
// depends on pidc_pkg
module pidc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
  output logic [pidc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pidc_pkg::cfg_t                cfg
);

  pidc_pkg::cfg_t cfg_r;
  pidc_pkg::cfg_reg_t idx;
  logic wr_en;

  assign idx    = pidc_pkg::cfg_reg_t'(paddr[pidc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= '0;
      cfg_r.gain_i    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.out_limit <= pidc_pkg::LIMIT_RESET;
      cfg_r.int_limit <= pidc_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        pidc_pkg::REG_GAIN_P: cfg_r.gain_p <= pwdata[pidc_pkg::VALUE_W-1:0];
        pidc_pkg::REG_GAIN_I: cfg_r.gain_i <= pwdata[pidc_pkg::VALUE_W-1:0];
        pidc_pkg::REG_GAIN_D: cfg_r.gain_d <= pwdata[pidc_pkg::VALUE_W-1:0];
        pidc_pkg::REG_OUT_LIMIT: begin
          // zero limit is ignored
          if (pwdata[pidc_pkg::LIM_W-1:0] != '0) begin
            cfg_r.out_limit <= pwdata[pidc_pkg::LIM_W-1:0];
          end
        end
        pidc_pkg::REG_INT_LIMIT: cfg_r.int_limit <= pwdata[pidc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidc_pkg::REG_GAIN_P:    prdata = cfg_r.gain_p;
      pidc_pkg::REG_GAIN_I:    prdata = cfg_r.gain_i;
      pidc_pkg::REG_GAIN_D:    prdata = cfg_r.gain_d;
      pidc_pkg::REG_OUT_LIMIT: prdata = {{(pidc_pkg::DATA_W-pidc_pkg::LIM_W){1'b0}},
                                         cfg_r.out_limit};
      pidc_pkg::REG_INT_LIMIT: prdata = {{(pidc_pkg::DATA_W-pidc_pkg::LIM_W){1'b0}},
                                         cfg_r.int_limit};
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/pidc_mul.sv
// pidc_mul: shared signed multiplier, registered product then floor shift and saturate
// depends on pidc_pkg; product and result are each registered, and done rises with the result
module pidc_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pidc_pkg::mul_req_t                  req,
  input  logic signed [pidc_pkg::VALUE_W:0]   a,
  input  logic signed [pidc_pkg::VALUE_W:0]   b,
  output logic                                done,
  output logic signed [pidc_pkg::VALUE_W-1:0] res
);

  localparam int PROD_W = 2 * (pidc_pkg::VALUE_W + 1);
  localparam logic signed [PROD_W-1:0] PMAX = PROD_W'(pidc_pkg::VMAX);
  localparam logic signed [PROD_W-1:0] PMIN = PROD_W'(pidc_pkg::VMIN);

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shifted;
  logic signed [pidc_pkg::VALUE_W-1:0] res_nxt;
  logic signed [pidc_pkg::VALUE_W-1:0] res_r;
  logic step_r;
  logic v1_r;
  logic done_r;

  assign prod_nxt = a * b;
  assign shifted  = step_r ? (prod_r >>> pidc_pkg::STEP_W) : (prod_r >>> pidc_pkg::FRAC_W);

  always_comb begin
    priority if (shifted > PMAX) begin
      res_nxt = pidc_pkg::VMAX;
    end else if (shifted < PMIN) begin
      res_nxt = pidc_pkg::VMIN;
    end else begin
      res_nxt = shifted[pidc_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.go;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= prod_nxt;
      step_r <= req.step_shift;
    end
    if (v1_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: rtl/core/pidc_div.sv
// pidc_div: radix-2 restoring divider, floor(|num| * 2^STEP_W / dt) with sign and saturation
// depends on pidc_pkg; one quotient bit per cycle
module pidc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pidc_pkg::VALUE_W-1:0] num,
  input  logic [pidc_pkg::STEP_W-1:0]         dt,
  output logic                                done,
  output logic signed [pidc_pkg::VALUE_W-1:0] quot
);

  localparam int VW    = pidc_pkg::VALUE_W;
  localparam int SW    = pidc_pkg::STEP_W;
  localparam int SH_W  = VW - 1 - SW;
  localparam int CNT_W = $clog2(VW);

  pidc_pkg::div_phase_t phase_r, phase_nxt;
  logic [VW-1:0]    mag_r;
  logic             neg_r;
  logic [SW-1:0]    dt_r;
  logic [SW-1:0]    rem_r;
  logic [VW-1:0]    sh_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [VW-1:0] quot_r;
  logic             done_r;

  logic             ovf;
  logic [SW:0]      trial;
  logic [SW:0]      diff;
  logic             ge;
  logic [SW-1:0]    rem_nxt;

  assign ovf     = mag_r >= {1'b0, dt_r, {SH_W{1'b0}}};
  assign trial   = {rem_r, sh_r[VW-1]};
  assign ge      = trial >= {1'b0, dt_r};
  assign diff    = trial - {1'b0, dt_r};
  assign rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      pidc_pkg::DIV_IDLE: if (start) phase_nxt = pidc_pkg::DIV_CHK;
      pidc_pkg::DIV_CHK:  phase_nxt = ovf ? pidc_pkg::DIV_IDLE : pidc_pkg::DIV_RUN;
      pidc_pkg::DIV_RUN:  if (cnt_r == '0) phase_nxt = pidc_pkg::DIV_FIN;
      pidc_pkg::DIV_FIN:  phase_nxt = pidc_pkg::DIV_IDLE;
      default:            phase_nxt = pidc_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pidc_pkg::DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= ((phase_r == pidc_pkg::DIV_CHK) && ovf) || (phase_r == pidc_pkg::DIV_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      pidc_pkg::DIV_IDLE: begin
        if (start) begin
          mag_r <= num[VW-1] ? (~num + 1'b1) : num;
          neg_r <= num[VW-1];
          dt_r  <= dt;
        end
      end
      pidc_pkg::DIV_CHK: begin
        if (ovf) begin
          quot_r <= neg_r ? pidc_pkg::VMIN : pidc_pkg::VMAX;
        end
        // upper quotient bits are zero here, so the upper dividend is the remainder
        rem_r <= mag_r[VW-1:VW-SW];
        sh_r  <= {mag_r[VW-SW-1:0], {SW{1'b0}}};
        cnt_r <= CNT_W'(VW - 1);
      end
      pidc_pkg::DIV_RUN: begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[VW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      pidc_pkg::DIV_FIN: begin
        quot_r <= neg_r ? -$signed(sh_r) : $signed(sh_r);
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: rtl/core/pid_controller_clamped_unit.sv
// pid_controller_clamped_unit: clamped pid step under a sequencer with one shared
// multiplier (product and result registered) and one radix-2 restoring divider
// the divider runs only with nonzero time step and stops early when the derivative
// saturates at once; with zero time step the integral increment and derivative are skipped
// input is taken the cycle after the result loads, so only one word is in flight at a time
// reset clears integral and previous error, gains to zero, both limits to 1.0
module pid_controller_clamped_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  pidc_in_if.sink                     in_ch,
  pidc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0] paddr,
  input  logic [pidc_pkg::DATA_W-1:0] pwdata,
  output logic [pidc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int VW = pidc_pkg::VALUE_W;

  function automatic logic signed [VW-1:0] clamp_mag(input logic signed [VW-1:0] x,
                                                     input logic [pidc_pkg::LIM_W-1:0] lim);
    logic signed [VW:0] xe;
    logic signed [VW:0] hi;
    logic signed [VW:0] lo;
    xe = {x[VW-1], x};
    hi = $signed({{(VW+1-pidc_pkg::LIM_W){1'b0}}, lim});
    lo = -hi;
    priority if (xe > hi) begin
      return hi[VW-1:0];
    end else if (xe < lo) begin
      return lo[VW-1:0];
    end else begin
      return x;
    end
  endfunction

  pidc_pkg::cfg_t cfg;
  pidc_pkg::pidc_state_t state_r, state_nxt;

  pidc_pkg::mul_req_t mul_req;
  logic signed [VW:0] mul_a, mul_b;
  logic               mul_done;
  logic signed [VW-1:0] mul_res;
  logic               div_go;
  logic               div_done;
  logic signed [VW-1:0] div_res;

  logic signed [VW-1:0] tgt_r, meas_r;
  logic [pidc_pkg::STEP_W-1:0] dt_r;
  logic signed [VW-1:0] err_r, integ_r, last_r, term_r, pi_r, d_r, total_r, drive_r;
  logic wait_r;
  logic out_valid_r;
  logic in_ready;
  logic out_free;
  logic accept;

  pidc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (term_r),
    .dt    (dt_r),
    .done  (div_done),
    .quot  (div_res)
  );

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // control outputs
  always_comb begin
    in_ready           = (state_r == pidc_pkg::ST_IDLE);
    mul_req.go         = 1'b0;
    mul_req.step_shift = 1'b0;
    mul_a              = {err_r[VW-1], err_r};
    mul_b              = {err_r[VW-1], err_r};
    div_go             = 1'b0;
    unique case (state_r)
      pidc_pkg::ST_INC: begin
        mul_req.go         = !wait_r;
        mul_req.step_shift = 1'b1;
        mul_b              = {{(VW+1-pidc_pkg::STEP_W){1'b0}}, dt_r};
      end
      pidc_pkg::ST_PROP: begin
        mul_req.go = !wait_r;
        mul_a      = {cfg.gain_p[VW-1], cfg.gain_p};
      end
      pidc_pkg::ST_INTG: begin
        mul_req.go = !wait_r;
        mul_a      = {cfg.gain_i[VW-1], cfg.gain_i};
        mul_b      = {integ_r[VW-1], integ_r};
      end
      pidc_pkg::ST_NUM: begin
        mul_req.go = !wait_r;
        mul_a      = {cfg.gain_d[VW-1], cfg.gain_d};
        mul_b      = {term_r[VW-1], term_r};
      end
      pidc_pkg::ST_DIV: div_go = !wait_r;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidc_pkg::ST_IDLE:  if (accept) state_nxt = pidc_pkg::ST_ERR;
      pidc_pkg::ST_ERR:   state_nxt = (dt_r != '0) ? pidc_pkg::ST_INC : pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_INC:   if (mul_done) state_nxt = pidc_pkg::ST_ACC;
      pidc_pkg::ST_ACC:   state_nxt = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: state_nxt = pidc_pkg::ST_PROP;
      pidc_pkg::ST_PROP:  if (mul_done) state_nxt = pidc_pkg::ST_INTG;
      pidc_pkg::ST_INTG: begin
        if (mul_done) state_nxt = (dt_r != '0) ? pidc_pkg::ST_DIFF : pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_DIFF:  state_nxt = pidc_pkg::ST_NUM;
      pidc_pkg::ST_NUM:   if (mul_done) state_nxt = pidc_pkg::ST_DIV;
      pidc_pkg::ST_DIV:   if (div_done) state_nxt = pidc_pkg::ST_SUM;
      pidc_pkg::ST_SUM:   state_nxt = pidc_pkg::ST_OUT;
      pidc_pkg::ST_OUT:   if (out_free) state_nxt = pidc_pkg::ST_IDLE;
      default:            state_nxt = pidc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidc_pkg::ST_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_req.go || div_go) begin
        wait_r <= 1'b1;
      end else if (mul_done || div_done) begin
        wait_r <= 1'b0;
      end
      if ((state_r == pidc_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        last_r      <= err_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_ch.restart) begin
        integ_r <= '0;
        last_r  <= '0;
      end
      if (state_r == pidc_pkg::ST_ACC) begin
        integ_r <= pidc_pkg::sat_ext({integ_r[VW-1], integ_r} + {term_r[VW-1], term_r});
      end
      if (state_r == pidc_pkg::ST_CLAMP) begin
        integ_r <= clamp_mag(integ_r, cfg.int_limit);
      end
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_r  <= in_ch.target;
      meas_r <= in_ch.measured;
      dt_r   <= in_ch.time_step;
    end
    unique case (state_r)
      pidc_pkg::ST_ERR: begin
        err_r <= pidc_pkg::sat_ext({tgt_r[VW-1], tgt_r} - {meas_r[VW-1], meas_r});
        d_r   <= '0;
      end
      pidc_pkg::ST_INC:  if (mul_done) term_r <= mul_res;
      pidc_pkg::ST_PROP: if (mul_done) term_r <= mul_res;
      pidc_pkg::ST_INTG: begin
        if (mul_done) begin
          pi_r <= pidc_pkg::sat_ext({term_r[VW-1], term_r} + {mul_res[VW-1], mul_res});
        end
      end
      pidc_pkg::ST_DIFF: begin
        term_r <= pidc_pkg::sat_ext({err_r[VW-1], err_r} - {last_r[VW-1], last_r});
      end
      pidc_pkg::ST_NUM:  if (mul_done) term_r <= mul_res;
      pidc_pkg::ST_DIV:  if (div_done) d_r <= div_res;
      pidc_pkg::ST_SUM: begin
        total_r <= pidc_pkg::sat_ext({pi_r[VW-1], pi_r} + {d_r[VW-1], d_r});
      end
      pidc_pkg::ST_OUT:  if (out_free) drive_r <= clamp_mag(total_r, cfg.out_limit);
      default: ;
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for pid_controller_clamped_unit, predicts each drive word
// from its own pid model; depends on pidc_pkg and the pidc_in_if / pidc_out_if channels
module tb;

  localparam int STEP_FRAC     = 20;
  localparam int PHASES        = 6;
  localparam int PHASE_STEPS   = 215;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;
  localparam logic signed [31:0]  ONE      = 32'sh0001_0000;
  localparam logic [30:0]         LIM_MAX  = 31'h7FFF_FFFF;
  localparam logic [STEP_FRAC-1:0] DT_MAX  = 20'hF_FFFF;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pidc_pkg::ADDR_W-1:0] paddr;
  logic [pidc_pkg::DATA_W-1:0] pwdata;
  logic [pidc_pkg::DATA_W-1:0] prdata;
  logic pready;

  pidc_in_if  in_bus ();
  pidc_out_if out_bus ();

  pid_controller_clamped_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // controller model: gains, limits and loop state
  logic signed [31:0] kp, ki, kd;
  logic [30:0]        out_lim, int_lim;
  logic signed [31:0] integ, prev_err;

  logic signed [31:0] drive_q [$];
  logic signed [31:0] want_drive;

  int  fails;
  int  steps_sent;
  int  words_checked;
  int  reg_writes;
  int  cycles;
  int  hold_off_left;
  bit  src_idle_on;
  bit  sink_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic signed [127:0] wide(input logic signed [31:0] v);
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
    if (x > WIDE_MAX) return pidc_pkg::VMAX;
    if (x < WIDE_MIN) return pidc_pkg::VMIN;
    return x[31:0];
  endfunction

  // exact product, floor shift, saturate
  function automatic logic signed [31:0] mul_floor(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int s);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return sat32((wa * wb) >>> s);
  endfunction

  function automatic logic signed [31:0] clamp_to(input logic signed [31:0] v,
                                                  input logic [30:0] m);
    logic signed [31:0] hi;
    hi = $signed({1'b0, m});
    if (v > hi) return hi;
    if (v < -hi) return -hi;
    return v;
  endfunction

  function automatic logic signed [31:0] next_drive(input logic signed [31:0] tgt,
                                                    input logic signed [31:0] meas,
                                                    input logic [STEP_FRAC-1:0] dt,
                                                    input bit rs);
    logic signed [31:0]  err, inc, p, i, d, diff, num, total;
    logic signed [127:0] quo;
    if (rs) begin
      integ = '0;
      prev_err = '0;
    end
    err = sat32(wide(tgt) - wide(meas));
    if (dt != 0) begin
      inc = mul_floor(err, $signed({44'd0, dt}), STEP_FRAC);
      integ = sat32(wide(integ) + wide(inc));
    end
    integ = clamp_to(integ, int_lim);
    p = mul_floor(kp, err, pidc_pkg::FRAC_W);
    i = mul_floor(ki, integ, pidc_pkg::FRAC_W);
    d = '0;
    if (dt != 0) begin
      diff = sat32(wide(err) - wide(prev_err));
      num = mul_floor(kd, diff, pidc_pkg::FRAC_W);
      // truncating divide of num scaled up by the step fraction
      quo = (wide(num) <<< STEP_FRAC) / $signed({108'd0, dt});
      d = sat32(quo);
    end
    prev_err = err;
    total = sat32(wide(sat32(wide(p) + wide(i))) + wide(d));
    return clamp_to(total, out_lim);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return pidc_pkg::VMAX;
    if (r < 8) return pidc_pkg::VMIN;
    if (r < 10) return '0;
    if (r < 40) return $urandom;
    return $urandom_range(0, 1048576) - 524288;
  endfunction

  function automatic logic signed [31:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return pidc_pkg::VMAX;
    if (r < 10) return pidc_pkg::VMIN;
    if (r < 30) return $urandom;
    return $urandom_range(0, 524288) - 262144;
  endfunction

  function automatic logic [STEP_FRAC-1:0] rand_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 13) return DT_MAX;
    if (r < 18) return 20'd1;
    if (r < 60) return STEP_FRAC'($urandom);
    return STEP_FRAC'($urandom_range(1, 16384));
  endfunction

  function automatic logic [30:0] rand_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return LIM_MAX;
    if (r < 25) return 31'd1;
    if (r < 45) return 31'($urandom);
    return 31'($urandom_range(4096, 16777216));
  endfunction

  // sink side: random stalls plus a long counted hold-off on request
  initial begin : sink_proc
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_off_left--;
      end else if (hold > 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else begin
        out_bus.ready <= 1'b1;
        if (sink_idle_on) hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (drive_q.size() == 0) begin
        $error("drive word with nothing expected: %0d", out_bus.drive);
        fails++;
      end else begin
        want_drive = drive_q.pop_front();
        if (out_bus.drive !== want_drive) begin
          $error("drive mismatch: expected %0d, actual %0d", want_drive, out_bus.drive);
          fails++;
        end
        words_checked++;
      end
    end
  end

  task automatic write_reg(input pidc_pkg::cfg_reg_t idx,
                           input logic [pidc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pidc_pkg::REG_GAIN_P: kp = val;
      pidc_pkg::REG_GAIN_I: ki = val;
      pidc_pkg::REG_GAIN_D: kd = val;
      pidc_pkg::REG_OUT_LIMIT: begin
        if (val[30:0] != 0) out_lim = val[30:0];
      end
      pidc_pkg::REG_INT_LIMIT: int_lim = val[30:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_all(input logic signed [31:0] gp, input logic signed [31:0] gi,
                         input logic signed [31:0] gd, input logic [30:0] ol,
                         input logic [30:0] il);
    write_reg(pidc_pkg::REG_GAIN_P, gp);
    write_reg(pidc_pkg::REG_GAIN_I, gi);
    write_reg(pidc_pkg::REG_GAIN_D, gd);
    write_reg(pidc_pkg::REG_OUT_LIMIT, {1'b0, ol});
    write_reg(pidc_pkg::REG_INT_LIMIT, {1'b0, il});
  endtask

  task automatic send_step(input logic signed [31:0] tgt, input logic signed [31:0] meas,
                           input logic [STEP_FRAC-1:0] dt, input bit rs);
    int gap;
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.target    <= tgt;
    in_bus.measured  <= meas;
    in_bus.time_step <= dt;
    in_bus.restart   <= rs;
    do @(posedge clk); while (!in_bus.ready);
    drive_q.push_back(next_drive(tgt, meas, dt, rs));
    steps_sent++;
    gap = src_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // default limits of 1.0 clamp a unit-gain response
  task automatic test_defaults();
    write_reg(pidc_pkg::REG_GAIN_P, ONE);
    send_step(5 * ONE, '0, 20'd1000, 1'b0);
    send_step(-5 * ONE, '0, 20'd1000, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    set_all(pidc_pkg::VMAX, pidc_pkg::VMIN, pidc_pkg::VMAX, LIM_MAX, LIM_MAX);
    send_step(pidc_pkg::VMAX, pidc_pkg::VMIN, DT_MAX, 1'b0);
    send_step(pidc_pkg::VMIN, pidc_pkg::VMAX, DT_MAX, 1'b0);
    send_step('0, '0, 20'd1, 1'b0);
    send_step(pidc_pkg::VMAX, '0, 20'd1, 1'b0);
    send_step(32'sd1, -32'sd1, DT_MAX, 1'b1);
    drain();
    set_all(pidc_pkg::VMIN, pidc_pkg::VMAX, pidc_pkg::VMIN, LIM_MAX, LIM_MAX);
    send_step(pidc_pkg::VMIN, '0, 20'd1, 1'b0);
    send_step('0, pidc_pkg::VMIN, DT_MAX, 1'b0);
    drain();
  endtask

  task automatic test_special_cases();
    set_all(ONE, 2 * ONE, ONE / 2, 31'(10 * ONE), 31'(3 * ONE));
    // zero step: no derivative, integral held
    send_step(3 * ONE, ONE, '0, 1'b0);
    send_step(2 * ONE, '0, '0, 1'b0);
    // restart together with zero step
    send_step(ONE, '0, '0, 1'b1);
    send_step(ONE, '0, 20'd10486, 1'b0);
    drain();
    // integral pinned at zero
    write_reg(pidc_pkg::REG_INT_LIMIT, '0);
    send_step(5 * ONE, '0, 20'h8_0000, 1'b0);
    send_step(-5 * ONE, '0, 20'h8_0000, 1'b0);
    drain();
    // zero output limit is ignored
    write_reg(pidc_pkg::REG_OUT_LIMIT, '0);
    send_step(100 * ONE, '0, 20'h0_1000, 1'b0);
    drain();
    write_reg(pidc_pkg::REG_OUT_LIMIT, 32'd1);
    send_step(100 * ONE, '0, 20'h0_1000, 1'b0);
    send_step(-100 * ONE, '0, 20'h0_1000, 1'b0);
    drain();
  endtask

  // long sink hold-off while words keep coming
  task automatic test_backpressure();
    set_all(ONE, ONE / 4, ONE / 8, LIM_MAX, LIM_MAX);
    src_idle_on = 1'b0;
    hold_off_left = HOLD_OFF_LEN;
    for (int n = 0; n < 20; n++) begin
      send_step(rand_value(), rand_value(), rand_dt(), $urandom_range(0, 9) == 0);
    end
    drain();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic signed [31:0]  tgt, meas;
    logic [STEP_FRAC-1:0] dt;
    logic [30:0]          ol, il;
    bit                   rs;
    tgt = '0;
    meas = '0;
    dt = 20'd1049;
    for (int ph = 0; ph < PHASES; ph++) begin
      ol = (ph == 0) ? LIM_MAX : (ph == 1) ? 31'd1 : rand_limit();
      il = (ph == 0) ? LIM_MAX : (ph == 1) ? 31'd0 : rand_limit();
      set_all(rand_gain(), rand_gain(), rand_gain(), ol, il);
      src_idle_on  = (ph % 4 == 1) || (ph % 4 == 3);
      sink_idle_on = (ph % 4 == 2) || (ph % 4 == 3);
      for (int n = 0; n < PHASE_STEPS; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          tgt = rand_value();
          meas = rand_value();
        end else begin
          // measurement settles toward the setpoint
          meas = meas + ((tgt - meas) >>> 2) + ($signed($urandom_range(0, 8192)) - 32'sd4096);
        end
        if ($urandom_range(0, 9) == 0) dt = rand_dt();
        rs = ($urandom_range(0, 19) == 0);
        send_step(tgt, meas, dt, rs);
      end
      drain();
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin : main_seq
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.target    = '0;
    in_bus.measured  = '0;
    in_bus.time_step = '0;
    in_bus.restart   = 1'b0;
    kp               = '0;
    ki               = '0;
    kd               = '0;
    out_lim          = pidc_pkg::LIMIT_RESET;
    int_lim          = pidc_pkg::LIMIT_RESET;
    integ            = '0;
    prev_err         = '0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    hold_off_left    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_extremes();
    test_special_cases();
    test_backpressure();
    test_random_traffic();

    $display("summary: %0d control steps, %0d drive words compared, %0d register writes",
             steps_sent, words_checked, reg_writes);
    $display("covered saturating errors, zero step, restart, zero and minimal limits, stalls");
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pidc_pkg.sv
rtl/core/pidc_if.sv
rtl/core/pidc_cfg.sv
rtl/core/pidc_mul.sv
rtl/core/pidc_div.sv
rtl/core/pid_controller_clamped_unit.sv
tb/tb.sv
